// ===== rtl/core/i2cbw_pkg.sv =====
// Shared types, constants and the control store of the I2C write master.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package i2cbw_pkg;

   // Command codes carried on the request tuser.
   localparam logic [2:0] FUNC_START   = 3'd0;
   localparam logic [2:0] FUNC_WRITE   = 3'd1;
   localparam logic [2:0] FUNC_ACK     = 3'd2;
   localparam logic [2:0] FUNC_NACK    = 3'd3;
   localparam logic [2:0] FUNC_STOP    = 3'd4;
   localparam logic [2:0] FUNC_RELEASE = 3'd5;

   // Configuration register indexes.
   localparam logic [1:0] CSR_ADDRESS    = 2'd0;
   localparam logic [1:0] CSR_SHORT_HOLD = 2'd1;
   localparam logic [1:0] CSR_LONG_HOLD  = 2'd2;

   // Register reset values.
   localparam logic [7:0]  ADDRESS_RESET    = 8'h78;
   localparam logic [15:0] SHORT_HOLD_RESET = 16'd90;
   localparam logic [15:0] LONG_HOLD_RESET  = 16'd450;

   // Byte images for the acknowledge bits: only bit 7 goes out.
   localparam logic [7:0] ACK_BYTE  = 8'h00;
   localparam logic [7:0] NACK_BYTE = 8'h80;

   // Bits per byte and the start's byte plus its acknowledge.
   localparam logic [3:0] BYTE_BITS  = 4'd8;
   localparam logic [3:0] START_BITS = 4'd9;

   // Release pulse count is capped so a release fits in 31 steps.
   localparam int MAX_PULSES = 12;

   localparam int PC_W = 5;
   localparam int CNT_W = 4;

   // Entry points and loop targets of the microprogram, and its last address.
   localparam logic [PC_W-1:0] PC_START   = 5'd0;
   localparam logic [PC_W-1:0] PC_BIT     = 5'd4;
   localparam logic [PC_W-1:0] PC_STOP    = 5'd7;
   localparam logic [PC_W-1:0] PC_RELEASE = 5'd10;
   localparam logic [PC_W-1:0] PC_PULSE   = 5'd12;
   localparam logic [PC_W-1:0] PC_LAST    = 5'd17;

   typedef enum logic [1:0] {
      SCL_KEEP = 2'd0,
      SCL_LO   = 2'd1,
      SCL_HI   = 2'd2
   } scl_op_type;

   typedef enum logic [1:0] {
      SDA_KEEP = 2'd0,
      SDA_LO   = 2'd1,
      SDA_HI   = 2'd2,
      SDA_BIT  = 2'd3
   } sda_op_type;

   // Sequencing of a control word: fall through, finish, or count-controlled
   // jump that either finishes or falls through when the count is spent.
   typedef enum logic [1:0] {
      BR_NEXT      = 2'd0,
      BR_END       = 2'd1,
      BR_LOOP_END  = 2'd2,
      BR_LOOP_NEXT = 2'd3
   } branch_type;

   typedef struct packed {
      scl_op_type      scl_op;
      sda_op_type      sda_op;
      logic            hold_long;
      logic            shift;
      branch_type      branch;
      logic [PC_W-1:0] target;
   } ucode_type;

   // Sequencer to datapath: one pin step fires, or a command is loaded.
   typedef struct packed {
      logic      load;
      logic [7:0] load_byte;
      logic      fire;
      ucode_type word;
      logic      last;
   } seq_ctl_type;

   function automatic ucode_type uword(scl_op_type c, sda_op_type d, logic lng,
                                       logic sh, branch_type br,
                                       logic [PC_W-1:0] tgt);
      ucode_type w;
      w.scl_op    = c;
      w.sda_op    = d;
      w.hold_long = lng;
      w.shift     = sh;
      w.branch    = br;
      w.target    = tgt;
      return w;
   endfunction

   // The control store.
   function automatic ucode_type ucode_rom(logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         // Start condition.
         5'd0:  w = uword(SCL_KEEP, SDA_HI,   1'b0, 1'b0, BR_NEXT, PC_START);
         5'd1:  w = uword(SCL_HI,   SDA_KEEP, 1'b0, 1'b0, BR_NEXT, PC_START);
         5'd2:  w = uword(SCL_KEEP, SDA_LO,   1'b0, 1'b0, BR_NEXT, PC_START);
         5'd3:  w = uword(SCL_LO,   SDA_KEEP, 1'b0, 1'b0, BR_NEXT, PC_START);
         // Bit loop: data, clock high, clock low and shift.
         5'd4:  w = uword(SCL_KEEP, SDA_BIT,  1'b0, 1'b0, BR_NEXT, PC_START);
         5'd5:  w = uword(SCL_HI,   SDA_KEEP, 1'b0, 1'b0, BR_NEXT, PC_START);
         5'd6:  w = uword(SCL_LO,   SDA_KEEP, 1'b0, 1'b1, BR_LOOP_END, PC_BIT);
         // Stop condition.
         5'd7:  w = uword(SCL_HI,   SDA_KEEP, 1'b0, 1'b0, BR_NEXT, PC_START);
         5'd8:  w = uword(SCL_KEEP, SDA_LO,   1'b0, 1'b0, BR_NEXT, PC_START);
         5'd9:  w = uword(SCL_KEEP, SDA_HI,   1'b0, 1'b0, BR_END,  PC_START);
         // Bus release with long holds.
         5'd10: w = uword(SCL_KEEP, SDA_HI,   1'b1, 1'b0, BR_NEXT, PC_START);
         5'd11: w = uword(SCL_HI,   SDA_KEEP, 1'b1, 1'b0, BR_NEXT, PC_START);
         5'd12: w = uword(SCL_LO,   SDA_KEEP, 1'b1, 1'b0, BR_NEXT, PC_START);
         5'd13: w = uword(SCL_HI,   SDA_KEEP, 1'b1, 1'b0, BR_LOOP_NEXT, PC_PULSE);
         5'd14: w = uword(SCL_LO,   SDA_KEEP, 1'b1, 1'b0, BR_NEXT, PC_START);
         5'd15: w = uword(SCL_KEEP, SDA_LO,   1'b1, 1'b0, BR_NEXT, PC_START);
         5'd16: w = uword(SCL_HI,   SDA_KEEP, 1'b1, 1'b0, BR_NEXT, PC_START);
         5'd17: w = uword(SCL_KEEP, SDA_HI,   1'b1, 1'b0, BR_END,  PC_START);
         default: w = uword(SCL_KEEP, SDA_KEEP, 1'b0, 1'b0, BR_END, PC_START);
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/core/i2cbw_seq.sv =====
// Microprogram sequencer: program counter, loop counter and command dispatch.
// Depends on i2cbw_pkg for the control store and the control struct.
`timescale 1ns / 1ps

module i2cbw_seq #(
   parameter int RELEASE_PULSES = 9
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [2:0]                req_func,
   input  logic [7:0]                req_byte,
   input  logic [7:0]                address_byte,
   input  logic                      space,
   output i2cbw_pkg::seq_ctl_type    ctl
);
   import i2cbw_pkg::*;

   localparam int PULSES = (RELEASE_PULSES > MAX_PULSES) ? MAX_PULSES : RELEASE_PULSES;
   localparam logic [CNT_W-1:0] PULSE_LOAD = CNT_W'(PULSES - 1);

   logic              busy_ff, busy_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   ucode_type         word;
   logic              accept;
   logic              fire;
   logic              cnt_zero;

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign fire       = busy_ff && space;
   assign word       = ucode_rom(pc_ff);
   assign cnt_zero   = (cnt_ff == '0);

   // Control handed to the datapath.
   always_comb begin
      ctl.fire = fire;
      ctl.word = word;
      ctl.last = (word.branch == BR_END) || ((word.branch == BR_LOOP_END) && cnt_zero);
      ctl.load = accept;
      case (req_func)
         FUNC_START: ctl.load_byte = address_byte;
         FUNC_WRITE: ctl.load_byte = req_byte;
         FUNC_NACK:  ctl.load_byte = NACK_BYTE;
         default:    ctl.load_byte = ACK_BYTE;
      endcase
   end

   // Dispatch a new command, or step through the program.
   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         busy_in = 1'b1;
         case (req_func)
            FUNC_START: begin
               pc_in  = PC_START;
               cnt_in = START_BITS - 4'd1;
            end
            FUNC_WRITE: begin
               pc_in  = PC_BIT;
               cnt_in = BYTE_BITS - 4'd1;
            end
            FUNC_ACK, FUNC_NACK: begin
               pc_in  = PC_BIT;
               cnt_in = '0;
            end
            FUNC_STOP: begin
               pc_in  = PC_STOP;
            end
            FUNC_RELEASE: begin
               pc_in  = PC_RELEASE;
               cnt_in = PULSE_LOAD;
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end else if (fire) begin
         case (word.branch)
            BR_NEXT: pc_in = pc_ff + 5'd1;
            BR_END:  busy_in = 1'b0;
            BR_LOOP_END: begin
               if (cnt_zero) begin
                  busy_in = 1'b0;
               end else begin
                  cnt_in = cnt_ff - 4'd1;
                  pc_in  = word.target;
               end
            end
            BR_LOOP_NEXT: begin
               if (cnt_zero) begin
                  pc_in = pc_ff + 5'd1;
               end else begin
                  cnt_in = cnt_ff - 4'd1;
                  pc_in  = word.target;
               end
            end
            default: busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= PC_START;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
         cnt_ff  <= cnt_in;
      end
   end

   // The program counter never leaves the control store while running.
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pc_ff <= PC_LAST))
      else $error("sequencer ran past the control store");

   // A command that is not defined starts nothing.
   a_unknown_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func != FUNC_START && req_func != FUNC_WRITE &&
       req_func != FUNC_ACK && req_func != FUNC_NACK && req_func != FUNC_STOP &&
       req_func != FUNC_RELEASE) |=> !busy_ff)
      else $error("unknown command started the sequencer");

   // The final step of a command always drops busy.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (fire && ctl.last) |=> !busy_ff)
      else $error("sequencer kept running after its last step");

endmodule

// ===== rtl/core/i2cbw_dp.sv =====
// Pin datapath: line state, byte shifter, hold selection and result register.
// Depends on i2cbw_pkg for the control struct and operation codes.
`timescale 1ns / 1ps

module i2cbw_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  i2cbw_pkg::seq_ctl_type ctl,
   input  logic [15:0]            short_hold,
   input  logic [15:0]            long_hold,
   output logic                   space,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic                   scl_level,
   output logic                   sda_level,
   output logic [15:0]            hold_ticks,
   output logic                   rsp_last
);
   import i2cbw_pkg::*;

   logic        scl_now_ff, scl_now_in;
   logic        sda_now_ff, sda_now_in;
   logic        valid_ff, valid_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] hold_ff, hold_in;
   logic        last_ff, last_in;
   logic [15:0] hold_sel;

   // The result slot takes a new step when empty or being drained.
   assign space = !valid_ff || rsp_tready;

   assign hold_sel = ctl.word.hold_long ? long_hold : short_hold;

   // Next line levels from the control word.
   always_comb begin
      case (ctl.word.scl_op)
         SCL_LO:  scl_now_in = 1'b0;
         SCL_HI:  scl_now_in = 1'b1;
         default: scl_now_in = scl_now_ff;
      endcase
      case (ctl.word.sda_op)
         SDA_LO:  sda_now_in = 1'b0;
         SDA_HI:  sda_now_in = 1'b1;
         SDA_BIT: sda_now_in = shift_ff[7];
         default: sda_now_in = sda_now_ff;
      endcase
   end

   // Shifter loads at dispatch and moves one bit after each clock-low step of the bit loop.
   always_comb begin
      shift_in = shift_ff;
      if (ctl.load) begin
         shift_in = ctl.load_byte;
      end else if (ctl.fire && ctl.word.shift) begin
         shift_in = {shift_ff[6:0], 1'b0};
      end
   end

   // Result register; a zero hold goes out as one tick.
   always_comb begin
      valid_in = valid_ff;
      hold_in  = hold_ff;
      last_in  = last_ff;
      if (ctl.fire) begin
         valid_in = 1'b1;
         hold_in  = (hold_sel == '0) ? 16'd1 : hold_sel;
         last_in  = ctl.last;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scl_now_ff <= 1'b1;
         sda_now_ff <= 1'b1;
         valid_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ctl.fire) begin
            scl_now_ff <= scl_now_in;
            sda_now_ff <= sda_now_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      hold_ff  <= hold_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign scl_level  = scl_now_ff;
   assign sda_level  = sda_now_ff;
   assign hold_ticks = hold_ff;
   assign rsp_last   = last_ff;

   // A step never overwrites a result that is still stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_tready) |-> !ctl.fire)
      else $error("pin step fired into a full result slot");

   // Line levels move only together with a new result.
   a_pins_with_step: assert property (@(posedge clock) disable iff (reset)
      !$past(ctl.fire) |-> ($stable(scl_now_ff) && $stable(sda_now_ff)))
      else $error("line level changed without a pin step");

   // An emitted hold is never zero.
   a_hold_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (hold_ff != 16'd0))
      else $error("zero hold emitted");

endmodule

// ===== rtl/core/i2c_bitbang_write_master_top.sv =====
// Top level of the write-only bit-banged I2C master.
// Holds the configuration registers; instantiates i2cbw_seq and i2cbw_dp.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tuser: func; tdata: data_byte
//   rsp      out        rsp_tvalid/rsp_tready  tdata: scl, sda, hold; tlast: last
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One command is taken at a time; it emits one pin step per cycle while the
// result side takes them; req_tready stays low until its last step has fired.
// The step rate is set by the single control-store read per step.
// Reset is synchronous and active high; lines reset released high.
// A stalled result holds the sequencer; config writes are always taken.
`timescale 1ns / 1ps

module i2c_bitbang_write_master_top #(
   parameter int RELEASE_PULSES = 9
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [2:0]  req_tuser,   // [2:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] scl_level, [1] sda_level, [17:2] hold_ticks
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import i2cbw_pkg::*;

   logic [7:0]  address_ff;
   logic [15:0] short_hold_ff;
   logic [15:0] long_hold_ff;
   seq_ctl_type ctl;
   logic        space;
   logic        scl_level;
   logic        sda_level;
   logic [15:0] hold_ticks;

   assign csr_ready = 1'b1;

   // Configuration registers; unlisted indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff    <= ADDRESS_RESET;
         short_hold_ff <= SHORT_HOLD_RESET;
         long_hold_ff  <= LONG_HOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ADDRESS:    address_ff    <= csr_data[7:0];
            CSR_SHORT_HOLD: short_hold_ff <= csr_data;
            CSR_LONG_HOLD:  long_hold_ff  <= csr_data;
            default:        ;
         endcase
      end
   end

   i2cbw_seq #(
      .RELEASE_PULSES (RELEASE_PULSES)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_func     (req_tuser),
      .req_byte     (req_tdata),
      .address_byte (address_ff),
      .space        (space),
      .ctl          (ctl)
   );

   i2cbw_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .short_hold (short_hold_ff),
      .long_hold  (long_hold_ff),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .scl_level  (scl_level),
      .sda_level  (sda_level),
      .hold_ticks (hold_ticks),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {6'b0, hold_ticks, sda_level, scl_level};

endmodule

// ===== sim/i2cbw_step_checker.sv =====
// Checker for the I2C write master: follows the request, result and CSR channels,
// predicts the pin steps of every accepted command, and compares each result item.
// Depends on i2cbw_pkg for the command codes and the register indexes.
`timescale 1ns / 1ps

module i2cbw_step_checker #(
   parameter int RELEASE_PULSES = 9
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [2:0]  req_tuser,   // [2:0] func
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [0] scl_level, [1] sda_level, [17:2] hold_ticks
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          error_count,
   output int          steps_pending
);
   import i2cbw_pkg::*;

   typedef struct packed {
      logic        scl;
      logic        sda;
      logic [15:0] hold;
      logic        last;
   } pin_step_type;

   // Pin steps still owed by the block, oldest first.
   pin_step_type steps_due[$];

   // Shadow copy of the registers and of the driven line levels.
   logic [7:0]  address_reg;
   logic [15:0] short_reg;
   logic [15:0] long_reg;
   logic        scl_line;
   logic        sda_line;
   int          mismatches = 0;

   assign error_count = mismatches;

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 100)
         $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   // One pin step: the lines take the new levels and hold them for a while.
   task automatic emit_step(input logic scl, input logic sda, input logic [15:0] hold);
      pin_step_type s;
      scl_line = scl;
      sda_line = sda;
      s.scl  = scl;
      s.sda  = sda;
      s.hold = (hold == 16'd0) ? 16'd1 : hold;
      s.last = 1'b0;
      steps_due.push_back(s);
   endtask

   // A bit is put on SDA, then SCL pulses high and comes back low.
   task automatic clock_out_bit(input logic b, input logic [15:0] hold);
      emit_step(scl_line, b, hold);
      emit_step(1'b1, sda_line, hold);
      emit_step(1'b0, sda_line, hold);
   endtask

   task automatic shift_out_byte(input logic [7:0] value);
      for (int i = 7; i >= 0; i--)
         clock_out_bit(value[i], short_reg);
   endtask

   // Expands one command into the pin steps that it should produce.
   task automatic predict_command(input logic [2:0] func, input logic [7:0] value);
      int           first;
      int           pulses;
      pin_step_type s;
      first  = steps_due.size();
      pulses = (RELEASE_PULSES > MAX_PULSES) ? MAX_PULSES : RELEASE_PULSES;
      case (func)
         FUNC_START: begin
            emit_step(scl_line, 1'b1, short_reg);
            emit_step(1'b1, sda_line, short_reg);
            emit_step(scl_line, 1'b0, short_reg);
            emit_step(1'b0, sda_line, short_reg);
            shift_out_byte(address_reg);
            clock_out_bit(1'b0, short_reg);
         end
         FUNC_WRITE: shift_out_byte(value);
         FUNC_ACK:   clock_out_bit(1'b0, short_reg);
         FUNC_NACK:  clock_out_bit(1'b1, short_reg);
         FUNC_STOP: begin
            emit_step(1'b1, sda_line, short_reg);
            emit_step(scl_line, 1'b0, short_reg);
            emit_step(scl_line, 1'b1, short_reg);
         end
         FUNC_RELEASE: begin
            emit_step(scl_line, 1'b1, long_reg);
            emit_step(1'b1, sda_line, long_reg);
            for (int i = 0; i < pulses; i++) begin
               emit_step(1'b0, sda_line, long_reg);
               emit_step(1'b1, sda_line, long_reg);
            end
            emit_step(1'b0, sda_line, long_reg);
            emit_step(scl_line, 1'b0, long_reg);
            emit_step(1'b1, sda_line, long_reg);
            emit_step(scl_line, 1'b1, long_reg);
         end
         default: ;
      endcase
      // The final step of the command carries the last flag.
      if (steps_due.size() > first) begin
         s = steps_due.pop_back();
         s.last = 1'b1;
         steps_due.push_back(s);
      end
   endtask

   task automatic check_step();
      pin_step_type want;
      if (steps_due.size() == 0) begin
         report_mismatch($sformatf("result item 0x%06h with nothing expected", rsp_tdata));
      end else begin
         want = steps_due.pop_front();
         if (rsp_tdata[0] !== want.scl)
            report_mismatch($sformatf("scl_level %b, expected %b", rsp_tdata[0], want.scl));
         if (rsp_tdata[1] !== want.sda)
            report_mismatch($sformatf("sda_level %b, expected %b", rsp_tdata[1], want.sda));
         if (rsp_tdata[17:2] !== want.hold)
            report_mismatch($sformatf("hold_ticks %0d, expected %0d",
                                      rsp_tdata[17:2], want.hold));
         if (rsp_tlast !== want.last)
            report_mismatch($sformatf("last %b, expected %b", rsp_tlast, want.last));
      end
   endtask

   // Register writes first, then new commands, then finished result items.
   always @(posedge clock) begin
      if (reset) begin
         address_reg = ADDRESS_RESET;
         short_reg   = SHORT_HOLD_RESET;
         long_reg    = LONG_HOLD_RESET;
         scl_line    = 1'b1;
         sda_line    = 1'b1;
         steps_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ADDRESS:    address_reg = csr_data[7:0];
               CSR_SHORT_HOLD: short_reg   = csr_data;
               CSR_LONG_HOLD:  long_reg    = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_command(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready)
            check_step();
      end
      steps_pending <= steps_due.size();
   end

endmodule

// ===== sim/i2c_bitbang_write_master_top_test.sv =====
// Testbench top for the I2C write master: clock, reset, command and register
// stimulus, result-side back-pressure and the verdict.
// Depends on i2cbw_pkg, i2c_bitbang_write_master_top and i2cbw_step_checker.
`timescale 1ns / 1ps

module i2c_bitbang_write_master_top_test;
   import i2cbw_pkg::*;

   localparam int RELEASE_PULSES  = 9;
   localparam int CYCLE_LIMIT     = 300000;
   localparam int DRAIN_CYCLES    = 40;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_ITEMS     = 20;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic [2:0]  req_tuser = FUNC_START;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_ADDRESS;
   logic [15:0] csr_data = 16'd0;

   int check_errors;
   int steps_pending;
   int cycle_count = 0;
   int items_sent = 0;
   bit req_fast = 1'b0;
   bit rsp_fast = 1'b0;
   bit hold_off_req = 1'b0;

   always #1 clock = ~clock;

   i2c_bitbang_write_master_top #(.RELEASE_PULSES(RELEASE_PULSES)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   i2cbw_step_checker #(.RELEASE_PULSES(RELEASE_PULSES)) checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .error_count(check_errors), .steps_pending(steps_pending)
   );

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result side: a random stall before each item, and one long hold-off on request.
   initial begin
      int stall;
      forever begin
         stall = rsp_fast ? 0 : $urandom_range(0, 5);
         if (hold_off_req) begin
            stall = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Offers one command item after a random gap; valid stays up if no gap follows.
   task automatic issue_command(input logic [2:0] func, input logic [7:0] value);
      int gap;
      gap = req_fast ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= func;
      req_tdata  <= value;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (func <= FUNC_RELEASE)
         items_sent++;
   endtask

   // Lets the block drain all steps, plus slack for commands that emit nothing.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (steps_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [15:0] value);
      csr_index <= index;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // A random bus transaction: mostly start, bytes with acks, stop; also
   // release, stray commands and broken sequences.
   task automatic run_transaction();
      int pick;
      int bytes;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         issue_command(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      end else if (pick < 24) begin
         issue_command(FUNC_RELEASE, 8'($urandom_range(0, 255)));
      end else begin
         bytes = $urandom_range(1, 3);
         issue_command(FUNC_START, 8'($urandom_range(0, 255)));
         for (int i = 0; i < bytes; i++) begin
            issue_command(FUNC_WRITE, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) < 6)
               issue_command(FUNC_ACK, 8'($urandom_range(0, 255)));
            else if ($urandom_range(0, 3) != 0)
               issue_command(FUNC_NACK, 8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 9) != 0)
            issue_command(FUNC_STOP, 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      int phase_start;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: every command, byte extremes, and the unused codes.
      req_fast = 1'b1;
      rsp_fast = 1'b1;
      issue_command(FUNC_START, 8'hFF);
      issue_command(FUNC_WRITE, 8'h00);
      issue_command(FUNC_WRITE, 8'hFF);
      issue_command(FUNC_WRITE, 8'hA5);
      issue_command(FUNC_ACK, 8'h00);
      issue_command(FUNC_NACK, 8'h00);
      issue_command(FUNC_STOP, 8'h00);
      issue_command(FUNC_RELEASE, 8'h00);
      issue_command(3'd6, 8'h3C);
      issue_command(3'd7, 8'hC3);
      issue_command(FUNC_STOP, 8'h00);
      wait_idle();

      // Address zero with junk in the upper data bits, a zero short hold and
      // the largest long hold.
      write_csr(CSR_ADDRESS, 16'hFF00);
      write_csr(CSR_SHORT_HOLD, 16'd0);
      write_csr(CSR_LONG_HOLD, 16'hFFFF);
      req_fast = 1'b0;
      rsp_fast = 1'b0;
      issue_command(FUNC_START, 8'h00);
      issue_command(FUNC_WRITE, 8'h5A);
      issue_command(FUNC_NACK, 8'h00);
      issue_command(FUNC_RELEASE, 8'hFF);
      issue_command(FUNC_STOP, 8'h00);
      wait_idle();

      // All-ones address, largest short hold, a zero long hold, and a write
      // to the unused register index.
      write_csr(CSR_ADDRESS, 16'h00FF);
      write_csr(CSR_SHORT_HOLD, 16'hFFFF);
      write_csr(CSR_LONG_HOLD, 16'd0);
      write_csr(CSR_UNUSED, 16'hFFFF);
      issue_command(FUNC_START, 8'h12);
      issue_command(FUNC_WRITE, 8'h81);
      issue_command(FUNC_ACK, 8'h00);
      issue_command(FUNC_RELEASE, 8'h00);
      issue_command(FUNC_STOP, 8'h00);
      issue_command(3'd7, 8'hFF);
      wait_idle();

      // Random phases, each under new register settings.
      for (int phase = 0; phase < 5; phase++) begin
         write_csr(CSR_ADDRESS, 16'($urandom_range(0, 65535)));
         case (phase)
            1: begin
               write_csr(CSR_SHORT_HOLD, 16'd1);
               write_csr(CSR_LONG_HOLD, 16'd1);
            end
            3: begin
               write_csr(CSR_SHORT_HOLD, 16'hFFFF);
               write_csr(CSR_LONG_HOLD, 16'hFFFF);
            end
            default: begin
               write_csr(CSR_SHORT_HOLD, 16'($urandom_range(1, 65535)));
               write_csr(CSR_LONG_HOLD, 16'($urandom_range(1, 65535)));
            end
         endcase
         req_fast = (phase == 2) || ($urandom_range(0, 3) == 0);
         rsp_fast = (phase == 2) || ($urandom_range(0, 3) == 0);
         // The long hold-off lets the block back up onto its request side.
         if (phase == 0)
            hold_off_req = 1'b1;
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS)
            run_transaction();
         wait_idle();
      end

      if (check_errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== i2c_bitbang_write_master_top.f =====
rtl/core/i2cbw_pkg.sv
rtl/core/i2cbw_seq.sv
rtl/core/i2cbw_dp.sv
rtl/core/i2c_bitbang_write_master_top.sv
sim/i2cbw_step_checker.sv
sim/i2c_bitbang_write_master_top_test.sv
